/* rtl/core/frsa_pkg.sv */
package frsa_pkg;

   // Ring and mark queue geometry
   localparam int SLOTS       = 1024;
   localparam int MARK_DEPTH  = 8;
   localparam int PTR_W       = $clog2(SLOTS);
   localparam int CNT_W       = $clog2(SLOTS + 1);
   localparam int MARK_IDX_W  = $clog2(MARK_DEPTH);
   localparam int MARK_CNT_W  = $clog2(MARK_DEPTH + 1);
   localparam int FENCE_W     = 64;
   localparam int FUNC_W      = 2;
   localparam int STATUS_W    = 2;

   // Request function codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC   = 2'd0,
      FUNC_MARK    = 2'd1,
      FUNC_RELEASE = 2'd2
   } func_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_RING_FULL  = 2'd1,
      STATUS_NO_MARK    = 2'd2,
      STATUS_QUEUE_FULL = 2'd3
   } status_type;

   // Controls from the ring logic to the mark queue
   typedef struct packed {
      logic             push;
      logic             pop;
      logic [FENCE_W-1:0] push_fence;
      logic [PTR_W-1:0]   push_ptr;
   } mark_ctrl_type;

   // Mark queue state seen by the ring logic
   typedef struct packed {
      logic             empty;
      logic             full;
      logic [FENCE_W-1:0] head_fence;
      logic [PTR_W-1:0]   head_ptr;
   } mark_stat_type;

   // One response
   typedef struct packed {
      status_type         status;
      logic [PTR_W-1:0]   slot_index;
      logic [FENCE_W-1:0] wait_fence;
      logic [CNT_W-1:0]   used_count;
   } rsp_type;

endpackage

/* rtl/core/frsa_mark_queue.sv */
module frsa_mark_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  frsa_pkg::mark_ctrl_type ctrl,
   output frsa_pkg::mark_stat_type stat
);

   localparam int SUM_W = frsa_pkg::MARK_CNT_W + 1;

   logic [frsa_pkg::FENCE_W-1:0]    fence_ff [frsa_pkg::MARK_DEPTH];
   logic [frsa_pkg::PTR_W-1:0]      ptr_ff   [frsa_pkg::MARK_DEPTH];
   logic [frsa_pkg::MARK_IDX_W-1:0] head_ff, head_in;
   logic [frsa_pkg::MARK_CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]                tail_sum;
   logic [SUM_W-1:0]                head_sum;
   logic [frsa_pkg::MARK_IDX_W-1:0] tail_idx;

   // Tail slot with wrap at the queue depth
   always_comb begin
      tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
      if (tail_sum >= SUM_W'(frsa_pkg::MARK_DEPTH)) begin
         tail_sum = tail_sum - SUM_W'(frsa_pkg::MARK_DEPTH);
      end
      tail_idx = tail_sum[frsa_pkg::MARK_IDX_W-1:0];
   end

   // Head and count update
   always_comb begin
      head_sum = SUM_W'(head_ff) + SUM_W'(1);
      if (head_sum >= SUM_W'(frsa_pkg::MARK_DEPTH)) begin
         head_sum = '0;
      end
      head_in  = head_ff;
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + frsa_pkg::MARK_CNT_W'(1);
      end else if (ctrl.pop) begin
         head_in  = head_sum[frsa_pkg::MARK_IDX_W-1:0];
         count_in = count_ff - frsa_pkg::MARK_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Mark storage, written at the tail
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         fence_ff[tail_idx] <= ctrl.push_fence;
         ptr_ff[tail_idx]   <= ctrl.push_ptr;
      end
   end

   assign stat.empty      = (count_ff == '0);
   assign stat.full       = (count_ff >= frsa_pkg::MARK_CNT_W'(frsa_pkg::MARK_DEPTH));
   assign stat.head_fence = fence_ff[head_ff];
   assign stat.head_ptr   = ptr_ff[head_ff];

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= frsa_pkg::MARK_CNT_W'(frsa_pkg::MARK_DEPTH))
      else $error("mark count above depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |-> !stat.full)
      else $error("push into full mark queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |-> !stat.empty)
      else $error("pop from empty mark queue");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not grow mark count");
`endif

endmodule

/* rtl/core/frsa_ring_ctrl.sv */
module frsa_ring_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [frsa_pkg::CNT_W-1:0]    csr_data,
   input  logic                          go,
   input  logic [frsa_pkg::FUNC_W-1:0]   func,
   input  logic [frsa_pkg::FENCE_W-1:0]  fence_value,
   input  frsa_pkg::mark_stat_type       mark_stat,
   output frsa_pkg::mark_ctrl_type       mark_ctrl,
   output frsa_pkg::rsp_type             rsp
);

   localparam int CW = frsa_pkg::CNT_W;

   logic [CW-1:0]              heap_ff, heap_in;
   logic [frsa_pkg::PTR_W-1:0] wp_ff, wp_in;
   logic [CW-1:0]              used_ff, used_in;
   logic [CW-1:0]              wp_next;
   logic [CW-1:0]              gap;
   logic [CW-1:0]              span;
   logic [CW-1:0]              heap_clamp;

   // Heap size write: zero acts as one, oversize acts as the full ring
   always_comb begin
      heap_clamp = csr_data;
      if (csr_data == '0) begin
         heap_clamp = CW'(1);
      end else if (csr_data > CW'(frsa_pkg::SLOTS)) begin
         heap_clamp = CW'(frsa_pkg::SLOTS);
      end
   end

   // Request decode and state update
   always_comb begin
      heap_in   = csr_write ? heap_clamp : heap_ff;
      wp_in     = wp_ff;
      used_in   = used_ff;
      mark_ctrl = '{push: 1'b0, pop: 1'b0, push_fence: fence_value, push_ptr: wp_ff};
      rsp       = '{status: frsa_pkg::STATUS_OK, slot_index: '0, wait_fence: '0,
                    used_count: used_ff};

      wp_next = CW'(wp_ff) + CW'(1);
      if (wp_next >= heap_ff) begin
         wp_next = '0;
      end

      // distance from release point to write pointer around the ring
      gap = CW'(mark_stat.head_ptr) - CW'(wp_ff);
      if (wp_ff >= mark_stat.head_ptr) begin
         span = CW'(wp_ff) - CW'(mark_stat.head_ptr);
      end else begin
         span = (gap > heap_ff) ? '0 : heap_ff - gap;
      end

      if (go) begin
         case (frsa_pkg::func_type'(func))
            frsa_pkg::FUNC_ALLOC: begin
               if (used_ff >= heap_ff) begin
                  rsp.status = frsa_pkg::STATUS_RING_FULL;
               end else begin
                  rsp.slot_index = wp_ff;
                  wp_in          = wp_next[frsa_pkg::PTR_W-1:0];
                  used_in        = used_ff + CW'(1);
               end
            end
            frsa_pkg::FUNC_MARK: begin
               if (mark_stat.full) begin
                  rsp.status = frsa_pkg::STATUS_QUEUE_FULL;
               end else begin
                  mark_ctrl.push = 1'b1;
               end
            end
            frsa_pkg::FUNC_RELEASE: begin
               if (mark_stat.empty) begin
                  rsp.status = frsa_pkg::STATUS_NO_MARK;
               end else begin
                  mark_ctrl.pop  = 1'b1;
                  rsp.wait_fence = mark_stat.head_fence;
                  used_in        = (span > heap_ff) ? heap_ff : span;
               end
            end
            default: begin
            end
         endcase
      end
      rsp.used_count = used_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_ff <= CW'(frsa_pkg::SLOTS);
         wp_ff   <= '0;
         used_ff <= '0;
      end else begin
         heap_ff <= heap_in;
         wp_ff   <= wp_in;
         used_ff <= used_in;
      end
   end

`ifndef ASSERT_OFF
   a_heap_range: assert property (@(posedge clock) disable iff (reset)
      heap_ff != '0 && heap_ff <= CW'(frsa_pkg::SLOTS))
      else $error("heap size out of range");

   a_alloc_grows: assert property (@(posedge clock) disable iff (reset)
      go && func == frsa_pkg::FUNC_ALLOC && rsp.status == frsa_pkg::STATUS_OK
      |=> used_ff == $past(used_ff) + 1'b1)
      else $error("allocate did not count slot");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      go && func == frsa_pkg::FUNC_RELEASE && !mark_stat.empty
      |-> rsp.used_count <= heap_ff)
      else $error("release count above heap size");
`endif

endmodule

/* rtl/core/fenced_ring_slot_allocator_top.sv */
// Channel | Direction | Handshake         | Payload
// req     | in        | req_valid/stall   | req_func, req_fence_value
// rsp     | out       | rsp_valid/stall   | rsp_status, rsp_slot_index,
//         |           |                   | rsp_wait_fence, rsp_used_count
// csr     | in        | csr_valid/ready   | csr_data (heap size)
//
// One request per cycle while req_stall is low; a request passes through the
// input register and one decode pass into the result register before its response is valid.
// Synchronous reset clears pointers, counts and the mark queue; heap size
// returns to the full ring. No clearing pass is needed.
// A stalled response holds the result register; the input register keeps
// taking one more request, then req_stall follows rsp_stall.
module fenced_ring_slot_allocator_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [frsa_pkg::FUNC_W-1:0]    req_func,
   input  logic [frsa_pkg::FENCE_W-1:0]   req_fence_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [frsa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [frsa_pkg::PTR_W-1:0]     rsp_slot_index,
   output logic [frsa_pkg::FENCE_W-1:0]   rsp_wait_fence,
   output logic [frsa_pkg::CNT_W-1:0]     rsp_used_count,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [frsa_pkg::CNT_W-1:0]     csr_data
);

   logic                          s1_valid_ff, s1_valid_in;
   logic [frsa_pkg::FUNC_W-1:0]   s1_func_ff;
   logic [frsa_pkg::FENCE_W-1:0]  s1_fence_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   frsa_pkg::rsp_type             rsp_ff;
   frsa_pkg::rsp_type             rsp_next;
   frsa_pkg::mark_ctrl_type       mark_ctrl;
   frsa_pkg::mark_stat_type       mark_stat;
   logic                          advance;
   logic                          go;

   // Pipeline flow
   assign advance      = !rsp_valid_ff || !rsp_stall;
   assign go           = s1_valid_ff && advance;
   assign req_stall    = s1_valid_ff && !advance;
   assign s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   assign csr_ready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_func_ff  <= req_func;
         s1_fence_ff <= req_fence_value;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (go) begin
         rsp_ff <= rsp_next;
      end
   end

   frsa_ring_ctrl u_ring (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .go          (go),
      .func        (s1_func_ff),
      .fence_value (s1_fence_ff),
      .mark_stat   (mark_stat),
      .mark_ctrl   (mark_ctrl),
      .rsp         (rsp_next)
   );

   frsa_mark_queue u_marks (
      .clock (clock),
      .reset (reset),
      .ctrl  (mark_ctrl),
      .stat  (mark_stat)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_slot_index = rsp_ff.slot_index;
   assign rsp_wait_fence = rsp_ff.wait_fence;
   assign rsp_used_count = rsp_ff.used_count;

endmodule

/* bench/fenced_ring_slot_allocator_top_tb.sv */
`timescale 1ns / 1ps

module fenced_ring_slot_allocator_top_tb;
   import frsa_pkg::*;

   // Selector with no operation behind it
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int IDLE_PCT = 18;

   // One pending entry: a request or a heap size write
   typedef struct {
      bit                 is_csr;
      logic [FUNC_W-1:0]  func;
      logic [FENCE_W-1:0] fence;
      logic [CNT_W-1:0]   heap;
   } pending_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [FUNC_W-1:0]   req_func = '0;
   logic [FENCE_W-1:0]  req_fence_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [PTR_W-1:0]    rsp_slot_index;
   logic [FENCE_W-1:0]  rsp_wait_fence;
   logic [CNT_W-1:0]    rsp_used_count;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CNT_W-1:0]    csr_data = '0;

   pending_type pending_q[$];
   rsp_type     expected_rsp_q[$];
   int          mismatches = 0;
   int          sent_count = 0;

   // Shadow of the allocator state
   logic [CNT_W-1:0]      ring_heap;
   logic [PTR_W-1:0]      ring_wr;
   logic [PTR_W-1:0]      ring_release;
   logic [CNT_W-1:0]      ring_used;
   logic [FENCE_W-1:0]    mark_fence_mem [MARK_DEPTH];
   logic [PTR_W-1:0]      mark_ptr_mem [MARK_DEPTH];
   logic [MARK_IDX_W-1:0] mark_head;
   logic [MARK_CNT_W-1:0] mark_count;

   fenced_ring_slot_allocator_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_fence_value (req_fence_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_wait_fence  (rsp_wait_fence),
      .rsp_used_count  (rsp_used_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Heap size write: out-of-range values clamp, release point follows
   function automatic void ring_set_heap(input logic [CNT_W-1:0] value);
      if (value == 0)
         ring_heap = CNT_W'(1);
      else if (value > SLOTS)
         ring_heap = CNT_W'(SLOTS);
      else
         ring_heap = value;
      ring_release = PTR_W'(ring_heap - 1'b1);
   endfunction

   // Expected response of one request, updating the shadow state
   function automatic rsp_type ring_apply_request(input logic [FUNC_W-1:0] func,
                                                  input logic [FENCE_W-1:0] fence);
      rsp_type               r;
      logic [MARK_IDX_W-1:0] pos;
      logic [CNT_W-1:0]      span;
      logic [CNT_W-1:0]      gap;
      r.status     = STATUS_OK;
      r.slot_index = '0;
      r.wait_fence = '0;
      case (func)
         FUNC_ALLOC: begin
            if (ring_used >= ring_heap) begin
               r.status = STATUS_RING_FULL;
            end else begin
               r.slot_index = ring_wr;
               // a pointer left past a shrunk heap wraps here too
               ring_wr = ({1'b0, ring_wr} + 1'b1 >= ring_heap) ? '0 : ring_wr + 1'b1;
               ring_used = ring_used + 1'b1;
            end
         end
         FUNC_MARK: begin
            if (mark_count >= MARK_DEPTH) begin
               r.status = STATUS_QUEUE_FULL;
            end else begin
               pos = mark_head + mark_count[MARK_IDX_W-1:0];
               mark_fence_mem[pos] = fence;
               mark_ptr_mem[pos]   = ring_wr;
               mark_count = mark_count + 1'b1;
            end
         end
         FUNC_RELEASE: begin
            if (mark_count == 0) begin
               r.status = STATUS_NO_MARK;
            end else begin
               r.wait_fence = mark_fence_mem[mark_head];
               ring_release = mark_ptr_mem[mark_head];
               mark_head  = mark_head + 1'b1;
               mark_count = mark_count - 1'b1;
               // distance modulo heap; stale pointers floor at zero
               if (ring_wr >= ring_release) begin
                  span = CNT_W'(ring_wr) - CNT_W'(ring_release);
               end else begin
                  gap  = CNT_W'(ring_release) - CNT_W'(ring_wr);
                  span = (gap > ring_heap) ? '0 : ring_heap - gap;
               end
               ring_used = (span > ring_heap) ? ring_heap : span;
            end
         end
         default: ;
      endcase
      r.used_count = ring_used;
      return r;
   endfunction

   function automatic logic [FENCE_W-1:0] pick_fence();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic bit no_idle_stretch();
      return sent_count >= 1200 && sent_count < 1500;
   endfunction

   task automatic add_req(input logic [FUNC_W-1:0] func, input logic [FENCE_W-1:0] fence);
      pending_type p;
      p.is_csr = 1'b0;
      p.func   = func;
      p.fence  = fence;
      p.heap   = '0;
      pending_q.push_back(p);
   endtask

   task automatic add_heap(input logic [CNT_W-1:0] value);
      pending_type p;
      p.is_csr = 1'b1;
      p.func   = '0;
      p.fence  = '0;
      p.heap   = value;
      pending_q.push_back(p);
   endtask

   // Mostly whole frames (allocations closed by a mark, often then a release), some noise
   task automatic add_frame_phase(input logic [CNT_W-1:0] heap, input int n_items);
      int left;
      int k;
      int roll;
      add_heap(heap);
      left = n_items;
      while (left > 0) begin
         roll = $urandom_range(99);
         if (roll < 75) begin
            k = $urandom_range(6);
            repeat (k) add_req(FUNC_ALLOC, pick_fence());
            add_req(FUNC_MARK, pick_fence());
            left -= k + 1;
            if ($urandom_range(99) < 60) begin
               add_req(FUNC_RELEASE, pick_fence());
               left--;
            end
         end else if (roll < 85) begin
            k = $urandom_range(9, 1);
            repeat (k) add_req(FUNC_MARK, pick_fence());
            left -= k;
         end else if (roll < 94) begin
            k = $urandom_range(4, 1);
            repeat (k) add_req(FUNC_RELEASE, pick_fence());
            left -= k;
         end else begin
            add_req(FUNC_UNUSED, pick_fence());
            left--;
         end
      end
   endtask

   // Request driver
   always @(posedge clock) begin
      pending_type nxt;
      logic        req_busy;
      logic        csr_busy;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
         ring_set_heap(CNT_W'(SLOTS));
         ring_wr    = '0;
         ring_used  = '0;
         mark_head  = '0;
         mark_count = '0;
      end else begin
         req_busy = req_valid;
         csr_busy = csr_valid;
         if (req_valid && !req_stall) begin
            expected_rsp_q.push_back(ring_apply_request(req_func, req_fence_value));
            sent_count++;
            req_busy = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            ring_set_heap(csr_data);
            csr_busy = 1'b0;
         end
         if (!req_busy && !csr_busy && pending_q.size() != 0) begin
            if (pending_q[0].is_csr) begin
               // heap size changes only with nothing in flight
               if (expected_rsp_q.size() == 0) begin
                  nxt = pending_q.pop_front();
                  csr_data <= nxt.heap;
                  csr_busy = 1'b1;
               end
            end else if (no_idle_stretch() || $urandom_range(99) >= IDLE_PCT) begin
               nxt = pending_q.pop_front();
               req_func        <= nxt.func;
               req_fence_value <= nxt.fence;
               req_busy = 1'b1;
            end
         end
         req_valid <= req_busy;
         csr_valid <= csr_busy;
      end
   end

   // Response checker
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response with no request outstanding", $realtime);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_status !== want.status || rsp_slot_index !== want.slot_index ||
                   rsp_wait_fence !== want.wait_fence ||
                   rsp_used_count !== want.used_count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: exp status %0d slot %0d fence %h used %0d, got %0d %0d %h %0d",
                              $realtime, want.status, want.slot_index, want.wait_fence,
                              want.used_count, rsp_status, rsp_slot_index, rsp_wait_fence,
                              rsp_used_count);
               end
            end
         end
         rsp_stall <= !no_idle_stretch() && ($urandom_range(99) < IDLE_PCT);
      end
   end

   initial begin
      // Directed: unused selector, empty release, queue overflow, then
      // shrink the heap under live pointers
      add_req(FUNC_UNUSED, '1);
      add_req(FUNC_RELEASE, '0);
      add_req(FUNC_MARK, '0);
      add_req(FUNC_MARK, '1);
      repeat (5) add_req(FUNC_ALLOC, pick_fence());
      repeat (6) add_req(FUNC_MARK, pick_fence());
      add_req(FUNC_MARK, pick_fence());
      add_req(FUNC_RELEASE, '1);
      add_heap(CNT_W'(2));
      add_req(FUNC_RELEASE, '0);          // saturates at heap size
      add_req(FUNC_ALLOC, '0);            // ring full
      add_req(FUNC_RELEASE, '0);          // equal pointers
      add_req(FUNC_ALLOC, '0);            // pointer past heap wraps
      add_req(FUNC_RELEASE, '0);          // stale pointer floors at zero
      repeat (3) add_req(FUNC_ALLOC, '1);

      // Fill the whole ring, clamped heap size
      add_heap(CNT_W'(1025));
      repeat (SLOTS + 4) add_req(FUNC_ALLOC, pick_fence());

      // Random frames over several heap sizes
      add_frame_phase(CNT_W'(0), 85);
      add_frame_phase(CNT_W'(1), 85);
      add_frame_phase(CNT_W'(2), 85);
      add_frame_phase(CNT_W'(3), 85);
      add_frame_phase(CNT_W'(7), 85);
      add_frame_phase(CNT_W'(2047), 85);
      add_frame_phase(CNT_W'(16), 85);
      add_frame_phase(CNT_W'($urandom_range(40, 4)), 85);
      add_frame_phase(CNT_W'($urandom_range(SLOTS, 1)), 85);
      add_frame_phase(CNT_W'(SLOTS), 85);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || req_valid || csr_valid || expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_rsp_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
